@@ hdl/anb_pkg.sv @@
// Shared types and constants for the Annex B unit splitter.
package anb_pkg;

  localparam int REC_DEPTH = 4;
  localparam int PTR_BITS  = 2;
  localparam int CNT_BITS  = 3;
  localparam int TDATA_BITS = 104;

  localparam logic [23:0] MAX_NAL_DEFAULT = 24'd1048576;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_START = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

  localparam logic [2:0] PREFIX_THREE = 3'd3;
  localparam logic [2:0] PREFIX_FOUR  = 3'd4;

  typedef enum logic [2:0] {
    PH_EXPECT = 3'b001,
    PH_INSIDE = 3'b010,
    PH_DROP   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [31:0] unit_index;
    logic [31:0] unit_offset;
    logic [2:0]  prefix_length;
    logic [23:0] payload_length;
    logic        hdr_f_bit;
    logic [1:0]  ref_idc;
    logic [4:0]  unit_type;
    logic [1:0]  status;
    logic        last_record;
  } rec_t;

  // Records produced by one byte: count is 0, 1 or 2, recs[0] first.
  typedef struct packed {
    logic [1:0]       count;
    rec_t [1:0]       recs;
  } push_t;

endpackage

@@ hdl/anb_parser.sv @@
// Start code detection, unit bookkeeping, record generation; one byte per in_fire cycle.
module anb_parser #(
  parameter int LENGTH_BITS = 24,
  parameter int OFFSET_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [23:0]    cfg_wdata,
  input  logic           in_fire,
  input  logic [7:0]     in_byte,
  input  logic           in_final,
  output anb_pkg::push_t push
);

  localparam int CW = (LENGTH_BITS > 24) ? LENGTH_BITS : 24;

  logic [23:0]            max_nal;
  logic [23:0]            window;
  logic [23:0]            window_next;
  anb_pkg::phase_t        phase;
  anb_pkg::phase_t        phase_next;
  logic                   four;
  logic                   four_next;
  logic [LENGTH_BITS-1:0] payload_count;
  logic [LENGTH_BITS-1:0] payload_count_next;
  logic [OFFSET_BITS-1:0] position;
  logic [OFFSET_BITS-1:0] position_next;
  logic [OFFSET_BITS-1:0] unit_start;
  logic [OFFSET_BITS-1:0] unit_start_next;
  logic [7:0]             header;
  logic [7:0]             header_next;
  logic [31:0]            units_reported;
  logic [31:0]            units_reported_next;
  logic                   oversize_seen;
  logic                   oversize_seen_next;

  logic                   m3;
  logic                   m4;
  logic                   pc_sat;
  logic [LENGTH_BITS-1:0] pc_inc;
  logic [7:0]             hdr_inc;
  logic [LENGTH_BITS-1:0] src_pc;
  logic [7:0]             src_hdr;
  logic                   src_ovs;
  logic [LENGTH_BITS-1:0] tail;
  logic [LENGTH_BITS-1:0] close_len;
  logic                   close_over;
  logic [7:0]             close_hdr;
  anb_pkg::rec_t          close_rec;
  logic                   open_four;
  logic [OFFSET_BITS-1:0] open_start;
  logic                   pos_lt2;
  logic                   pos_eq2;

  assign m3 = (in_byte == 8'h01) && (window[7:0] == 8'h00) && (window[15:8] == 8'h00);
  assign m4 = m3 && (window[23:16] == 8'h00);

  // Counter as it stands after this byte is taken as payload
  assign pc_sat  = &payload_count;
  assign pc_inc  = pc_sat ? payload_count : payload_count + LENGTH_BITS'(1);
  assign hdr_inc = (payload_count == '0) ? in_byte : header;

  assign src_pc  = m3 ? payload_count : pc_inc;
  assign src_hdr = m3 ? header : hdr_inc;
  assign src_ovs = m3 ? oversize_seen : (oversize_seen | pc_sat);
  assign tail    = m3 ? (m4 ? LENGTH_BITS'(3) : LENGTH_BITS'(2)) : '0;

  assign close_len  = (src_pc >= tail) ? src_pc - tail : '0;
  assign close_over = src_ovs || (CW'(close_len) > CW'(max_nal));
  assign close_hdr  = (close_len != '0) ? src_hdr : 8'h00;

  always_comb begin
    close_rec                = '0;
    close_rec.unit_index     = units_reported;
    close_rec.unit_offset    = 32'(unit_start);
    close_rec.prefix_length  = four ? anb_pkg::PREFIX_FOUR : anb_pkg::PREFIX_THREE;
    close_rec.payload_length = close_over ? max_nal : 24'(close_len);
    close_rec.hdr_f_bit      = close_hdr[7];
    close_rec.ref_idc        = close_hdr[6:5];
    close_rec.unit_type      = close_hdr[4:0];
    close_rec.status         = close_over ? anb_pkg::ST_OVERSIZE : anb_pkg::ST_OK;
  end

  assign pos_lt2 = position < OFFSET_BITS'(2);
  assign pos_eq2 = position == OFFSET_BITS'(2);

  // Opening prefix: in PH_EXPECT three bytes at position 2, later four; else four on m4
  assign open_four  = (phase == anb_pkg::PH_EXPECT) ? !pos_eq2 : m4;
  assign open_start = position - (open_four ? OFFSET_BITS'(3) : OFFSET_BITS'(2));

  always_comb begin
    logic          started;
    logic          err;
    logic          closed;
    anb_pkg::rec_t empty_rec;

    window_next         = {window[15:0], in_byte};
    position_next       = position + OFFSET_BITS'(1);
    phase_next          = phase;
    four_next           = four;
    payload_count_next  = payload_count;
    unit_start_next     = unit_start;
    header_next         = header;
    units_reported_next = units_reported;
    oversize_seen_next  = oversize_seen;
    push                = '0;
    started             = 1'b0;
    err                 = 1'b0;
    closed              = 1'b0;

    empty_rec               = '0;
    empty_rec.unit_offset   = 32'(open_start);
    empty_rec.prefix_length = open_four ? anb_pkg::PREFIX_FOUR : anb_pkg::PREFIX_THREE;
    empty_rec.status        = anb_pkg::ST_OK;

    unique case (phase)
      anb_pkg::PH_EXPECT: begin
        if (pos_lt2) begin
          err = (in_byte != 8'h00);
        end else if (pos_eq2) begin
          started = (in_byte == 8'h01);
          err     = (in_byte != 8'h01) && (in_byte != 8'h00);
        end else begin
          started = (in_byte == 8'h01) && (window[7:0] == 8'h00);
          err     = !started;
        end
        if (!started && (err || in_final)) begin
          push.count                   = 2'd1;
          push.recs[0]                 = '0;
          push.recs[0].unit_index      = units_reported;
          push.recs[0].unit_offset     = 32'(position);
          push.recs[0].status          = anb_pkg::ST_NO_START;
          phase_next                   = anb_pkg::PH_DROP;
        end else if (started && in_final) begin
          push.count = 2'd1;
          push.recs[0] = empty_rec;
          push.recs[0].unit_index = units_reported;
        end
      end
      anb_pkg::PH_INSIDE: begin
        if (m3) begin
          started      = 1'b1;
          closed       = 1'b1;
          push.count   = 2'd1;
          push.recs[0] = close_rec;
          if (in_final) begin
            push.count   = 2'd2;
            push.recs[1] = empty_rec;
            push.recs[1].unit_index = units_reported + 32'd1;
          end
        end else begin
          payload_count_next = pc_inc;
          header_next        = hdr_inc;
          oversize_seen_next = oversize_seen | pc_sat;
          if (in_final) begin
            closed       = 1'b1;
            push.count   = 2'd1;
            push.recs[0] = close_rec;
          end
        end
      end
      anb_pkg::PH_DROP: begin
        if (m3) begin
          started = 1'b1;
          if (in_final) begin
            push.count   = 2'd1;
            push.recs[0] = empty_rec;
            push.recs[0].unit_index = units_reported;
          end
        end
      end
      default: begin
        phase_next = anb_pkg::PH_EXPECT;
      end
    endcase

    if (started) begin
      four_next          = open_four;
      unit_start_next    = open_start;
      payload_count_next = '0;
      header_next        = 8'h00;
      oversize_seen_next = 1'b0;
      phase_next         = anb_pkg::PH_INSIDE;
    end

    // Error records leave the unit count alone
    units_reported_next = units_reported + 32'(closed)
                          + 32'(started && in_final);

    if (push.count == 2'd1) begin
      push.recs[0].last_record = 1'b1;
    end else if (push.count == 2'd2) begin
      push.recs[1].last_record = 1'b1;
    end

    // End of stream: back to the opening state
    if (in_final) begin
      window_next         = '0;
      position_next       = '0;
      phase_next          = anb_pkg::PH_EXPECT;
      four_next           = 1'b0;
      payload_count_next  = '0;
      unit_start_next     = '0;
      header_next         = 8'h00;
      units_reported_next = '0;
      oversize_seen_next  = 1'b0;
    end

    if (!in_fire) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_nal        <= anb_pkg::MAX_NAL_DEFAULT;
      window         <= '0;
      phase          <= anb_pkg::PH_EXPECT;
      four           <= 1'b0;
      payload_count  <= '0;
      position       <= '0;
      unit_start     <= '0;
      header         <= 8'h00;
      units_reported <= '0;
      oversize_seen  <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_nal <= cfg_wdata;
      end
      if (in_fire) begin
        window         <= window_next;
        phase          <= phase_next;
        four           <= four_next;
        payload_count  <= payload_count_next;
        position       <= position_next;
        unit_start     <= unit_start_next;
        header         <= header_next;
        units_reported <= units_reported_next;
        oversize_seen  <= oversize_seen_next;
      end
    end
  end

endmodule

@@ hdl/anb_rec_fifo.sv @@
// Four-entry record queue: takes up to two records a cycle, hands out one.
module anb_rec_fifo (
  input  logic           clk,
  input  logic           rst,
  input  anb_pkg::push_t push,
  input  logic           out_ready,
  output logic           out_valid,
  output anb_pkg::rec_t  out_rec,
  output logic           room
);

  anb_pkg::rec_t                  entries [anb_pkg::REC_DEPTH];
  logic [anb_pkg::PTR_BITS-1:0]   wr_ptr;
  logic [anb_pkg::PTR_BITS-1:0]   rd_ptr;
  logic [anb_pkg::CNT_BITS-1:0]   count;
  logic                           pop;

  assign out_valid = (count != '0);
  assign out_rec   = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  // Two free slots cover the worst case of one byte
  assign room      = count <= anb_pkg::CNT_BITS'(anb_pkg::REC_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.recs[0];
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + anb_pkg::PTR_BITS'(1)] <= push.recs[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + anb_pkg::PTR_BITS'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + anb_pkg::PTR_BITS'(1);
      end
      count <= count + anb_pkg::CNT_BITS'(push.count) - anb_pkg::CNT_BITS'(pop);
    end
  end

endmodule

@@ hdl/annexb_nal_unit_splitter_top.sv @@
// Top level of the H.264 Annex B unit splitter: stream ports and configuration register.
//
// Takes one byte of an Annex B stream per transfer on the slave side, s_axis_tlast marking
// the final byte, and reports one record per unit on the master side. A record for a unit
// is produced when the next start code completes (its last 01 byte) or at the final byte;
// a final byte may produce two records (the closed unit and an empty trailing one), the
// second carrying tlast. The parser takes a byte every cycle with tready high: all work
// for a byte is a three-byte window compare, one subtract and compare on the length
// counter, and the state update. Records pass through a four-entry queue; with the queue
// empty, the first record of a byte appears on the master side in the cycle after its
// transfer and a second once the first is taken. s_axis_tready drops only while fewer
// than two queue slots are free, which happens when the master side stalls. max_nal_bytes
// is written through cfg_we/cfg_wdata and should change only while the block is idle. No
// clearing pass follows reset; the block accepts bytes on the first cycle after rst falls.
module annexb_nal_unit_splitter_top #(
  parameter int LENGTH_BITS = 24,
  parameter int OFFSET_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [23:0]                     cfg_wdata,      // max_nal_bytes
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // stream_byte
  input  logic                            s_axis_tlast,   // final_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // unit_index[31:0], unit_offset[63:32], prefix_length[66:64], payload_length[90:67],
  // hdr_f_bit[91], ref_idc[93:92], unit_type[98:94], status[100:99], zero fill above
  output logic [anb_pkg::TDATA_BITS-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast    // last_record
);

  logic           in_fire;
  logic           room;
  anb_pkg::push_t push;
  anb_pkg::rec_t  out_rec;

  // Accept a byte whenever the queue can absorb the worst case of two records
  assign s_axis_tready = room;
  assign in_fire       = s_axis_tvalid && room;

  anb_parser #(
    .LENGTH_BITS (LENGTH_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_byte   (s_axis_tdata),
    .in_final  (s_axis_tlast),
    .push      (push)
  );

  anb_rec_fifo u_rec_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_rec   (out_rec),
    .room      (room)
  );

  // Pack the record, first field in the lowest bits
  assign m_axis_tdata = {3'b000, out_rec.status, out_rec.unit_type, out_rec.ref_idc,
                         out_rec.hdr_f_bit, out_rec.payload_length,
                         out_rec.prefix_length, out_rec.unit_offset, out_rec.unit_index};
  assign m_axis_tlast = out_rec.last_record;

endmodule

@@ verif/annexb_nal_unit_splitter_top_test.sv @@
// Self-checking testbench for the Annex B unit splitter: random streams against a predictor.
`timescale 1ns / 1ps

module annexb_nal_unit_splitter_top_test;

  // Predicts the unit records from every accepted byte and checks each record the block
  // hands out against the oldest one still due.
  class splitter_scoreboard;
    anb_pkg::rec_t   due_q[$];
    int unsigned     errors;
    logic [23:0]     max_len;
    // parser state, cleared at the end of every stream
    logic [23:0]     window;
    anb_pkg::phase_t phase;
    bit              four;
    logic [23:0]     count;
    logic [31:0]     pos;
    logic [31:0]     start;
    logic [31:0]     units;
    logic [7:0]      hdr;
    bit              over;

    function new();
      max_len = anb_pkg::MAX_NAL_DEFAULT;
      errors  = 0;
      restart_stream();
    endfunction

    function void restart_stream();
      window = '0;
      phase  = anb_pkg::PH_EXPECT;
      four   = 1'b0;
      count  = '0;
      pos    = '0;
      start  = '0;
      units  = '0;
      hdr    = '0;
      over   = 1'b0;
    endfunction

    function anb_pkg::rec_t make_rec(logic [31:0] offset, logic [2:0] plen,
                                     logic [23:0] len, logic [7:0] h, logic [1:0] st);
      anb_pkg::rec_t r;
      r.unit_index     = units;
      r.unit_offset    = offset;
      r.prefix_length  = plen;
      r.payload_length = len;
      r.hdr_f_bit      = h[7];
      r.ref_idc        = h[6:5];
      r.unit_type      = h[4:0];
      r.status         = st;
      r.last_record    = 1'b0;
      return r;
    endfunction

    function void open_unit(bit is_four);
      four  = is_four;
      start = pos - (is_four ? 32'd3 : 32'd2);
      count = '0;
      hdr   = '0;
      over  = 1'b0;
      phase = anb_pkg::PH_INSIDE;
    endfunction

    // tail: start-code bytes already counted into the payload
    function anb_pkg::rec_t close_unit(logic [23:0] tail);
      logic [23:0]   len;
      logic [7:0]    h;
      logic [1:0]    st;
      anb_pkg::rec_t r;
      len = (count >= tail) ? count - tail : 24'd0;
      h   = (len != 0) ? hdr : 8'h00;
      st  = anb_pkg::ST_OK;
      if (over || len > max_len) begin
        st  = anb_pkg::ST_OVERSIZE;
        len = max_len;
      end
      r = make_rec(start, four ? anb_pkg::PREFIX_FOUR : anb_pkg::PREFIX_THREE, len, h, st);
      units++;
      return r;
    endfunction

    function anb_pkg::rec_t empty_rec();
      anb_pkg::rec_t r;
      r = make_rec(start, four ? anb_pkg::PREFIX_FOUR : anb_pkg::PREFIX_THREE, 24'd0,
                   8'h00, anb_pkg::ST_OK);
      units++;
      return r;
    endfunction

    function void note_byte(logic [7:0] b, bit fin);
      anb_pkg::rec_t out_q[$];
      anb_pkg::rec_t r;
      logic [7:0]    p1, p2, p3;
      bit            m3, m4, err, started;
      p1 = window[7:0];
      p2 = window[15:8];
      p3 = window[23:16];
      m3 = (b == 8'h01) && (p1 == 8'h00) && (p2 == 8'h00);
      m4 = m3 && (p3 == 8'h00);
      err = 1'b0;
      started = 1'b0;
      case (phase)
        anb_pkg::PH_EXPECT: begin
          if (pos < 2) begin
            err = (b != 8'h00);
          end else if (pos == 2) begin
            if (b == 8'h01) begin
              open_unit(1'b0);
              started = 1'b1;
            end else if (b != 8'h00) begin
              err = 1'b1;
            end
          end else if (b == 8'h01 && p1 == 8'h00) begin
            open_unit(1'b1);
            started = 1'b1;
          end else begin
            err = 1'b1;
          end
          if (!started && (err || fin)) begin
            out_q.push_back(make_rec(pos, 3'd0, 24'd0, 8'h00, anb_pkg::ST_NO_START));
            phase = anb_pkg::PH_DROP;
          end else if (started && fin) begin
            out_q.push_back(empty_rec());
          end
        end
        anb_pkg::PH_INSIDE: begin
          if (m3) begin
            out_q.push_back(close_unit(m4 ? 24'd3 : 24'd2));
            open_unit(m4);
            if (fin) out_q.push_back(empty_rec());
          end else begin
            if (count == 0) hdr = b;
            if (count == 24'hFFFFFF) over = 1'b1;
            else count++;
            if (fin) out_q.push_back(close_unit(24'd0));
          end
        end
        default: begin
          // dropping after a bad opening: resync on the next start code
          if (m3) begin
            open_unit(m4);
            if (fin) out_q.push_back(empty_rec());
          end
        end
      endcase
      window = {window[15:0], b};
      pos++;
      if (out_q.size() != 0) begin
        r = out_q.pop_back();
        r.last_record = 1'b1;
        out_q.push_back(r);
      end
      foreach (out_q[i]) due_q.push_back(out_q[i]);
      if (fin) restart_stream();
    endfunction

    task report(string msg);
      errors++;
      $display("%0t ns: %s", $time, msg);
    endtask

    task check_field(logic [31:0] idx, string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("unit %0d: %s is 0x%0h, expected 0x%0h", idx, name, got, want));
    endtask

    task check_record(logic [anb_pkg::TDATA_BITS-1:0] d, logic lst);
      anb_pkg::rec_t w;
      if (due_q.size() == 0) begin
        report($sformatf("record for unit %0d with none due", d[31:0]));
        return;
      end
      w = due_q.pop_front();
      check_field(w.unit_index, "unit_index",     d[31:0],    w.unit_index);
      check_field(w.unit_index, "unit_offset",    d[63:32],   w.unit_offset);
      check_field(w.unit_index, "prefix_length",  d[66:64],   w.prefix_length);
      check_field(w.unit_index, "payload_length", d[90:67],   w.payload_length);
      check_field(w.unit_index, "hdr_f_bit",      d[91],      w.hdr_f_bit);
      check_field(w.unit_index, "ref_idc",        d[93:92],   w.ref_idc);
      check_field(w.unit_index, "unit_type",      d[98:94],   w.unit_type);
      check_field(w.unit_index, "status",         d[100:99],  w.status);
      check_field(w.unit_index, "last_record",    lst,        w.last_record);
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [23:0]                    cfg_wdata = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata = '0;
  logic                           s_axis_tlast = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [anb_pkg::TDATA_BITS-1:0] m_axis_tdata;
  logic                           m_axis_tlast;

  splitter_scoreboard sb = new();

  // Stream under construction, sent as one run ending on its final byte.
  logic [7:0] stream_q[$];
  bit         calm = 1'b0;   // no idling on either side in the closing part
  int         send_level = 1;
  int         recv_level = 1;
  int         stall_left = 0;
  int         sent = 0;

  annexb_nal_unit_splitter_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Bias towards 00 and 01 so that start codes, near misses and empty units turn up
  // inside payloads as well as where the generator places them.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r < 4) return 8'h00;
    if (r < 6) return 8'h01;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_prefix();
    if ($urandom_range(0, 1) != 0) stream_q.push_back(8'h00);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'h00);
    stream_q.push_back(8'h01);
  endfunction

  // Mostly short units, now and then an empty one, a few long ones.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 15);
    if (r < 2) return 0;
    if (r < 13) return $urandom_range(1, 12);
    return $urandom_range(13, 60);
  endfunction

  function automatic void build_stream();
    int kind;
    int n;
    stream_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      // very short stream, usually ending before any start code
      repeat ($urandom_range(1, 3)) stream_q.push_back(pick_byte());
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 30)) stream_q.push_back(pick_byte());
    end else begin
      // well-formed units; kind 7 spoils the opening with a few stray bytes first
      if (kind == 7) repeat ($urandom_range(1, 3)) stream_q.push_back(pick_byte());
      repeat ($urandom_range(1, 6)) begin
        push_prefix();
        n = pick_len();
        repeat (n) stream_q.push_back(pick_byte());
      end
      // trailing start code with no payload
      if ($urandom_range(0, 3) == 0) push_prefix();
    end
  endfunction

  // Hold the byte until the transfer happens, then let the predictor see it.
  task automatic send_byte(logic [7:0] b, bit fin);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_byte(b, fin);
    sent++;
    if (sent % 32 == 0) send_level = $urandom_range(0, 4);
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) begin
      // drop tvalid for a burst now and then; level 0 gives stretches without gaps
      if (!calm && $urandom_range(0, 15) < send_level) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      send_byte(stream_q[i], i == stream_q.size() - 1);
    end
  endtask

  task automatic run_phase(int budget);
    int target;
    target = sent + budget;
    while (sent < target) begin
      build_stream();
      send_stream();
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Wait for every due record, then for bytes still in the parser.
  task automatic wait_idle();
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [23:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.max_len = v;
  endtask

  // Master side: check each record transfer, stall in random bursts.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_record(m_axis_tdata, m_axis_tlast);
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 15) < recv_level) stall_left = $urandom_range(1, 12);
      end
      if ($urandom_range(0, 63) == 0) recv_level = $urandom_range(0, 5);
    end
  end

  initial begin
    logic [23:0] limits[$];
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed streams under the reset limit.
    // lone 0xFF: stream ends at once on a bad opening
    stream_q = '{8'hFF};
    send_stream();
    // lone zero: stream ends before any start code
    stream_q = '{8'h00};
    send_stream();
    // four-byte prefix, unit with header FF, then a trailing three-byte start code
    stream_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h01};
    send_stream();
    // bad third byte, drop until resync, one-byte unit
    stream_q = '{8'h00, 8'h00, 8'h02, 8'h07, 8'h00, 8'h00, 8'h01, 8'h25};
    send_stream();
    // back-to-back start codes: empty unit in the middle and an empty trailing one
    stream_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01};
    send_stream();
    s_axis_tvalid <= 1'b0;

    // Random streams across limit settings, the extremes among them; zero and one make
    // almost every unit oversize.
    limits.push_back(anb_pkg::MAX_NAL_DEFAULT);
    limits.push_back(24'd1);
    limits.push_back(24'd0);
    limits.push_back(24'hFFFFFF);
    limits.push_back(24'($urandom_range(2, 16)));
    limits.push_back(24'($urandom_range(17, 200)));
    limits.push_back(24'($urandom_range(1, 24'hFFFFFF)));
    foreach (limits[i]) begin
      wait_idle();
      write_limit(limits[i]);
      run_phase(120);
    end

    // closing part at full rate on both sides
    wait_idle();
    calm = 1'b1;
    write_limit(24'($urandom_range(1, 40)));
    run_phase(130);
    wait_idle();

    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/anb_pkg.sv
hdl/anb_parser.sv
hdl/anb_rec_fifo.sv
hdl/annexb_nal_unit_splitter_top.sv
verif/annexb_nal_unit_splitter_top_test.sv
